// ----- hw/rtl/wrh_pkg.sv -----
// ----------------------------------------------------------------------------
// wrh_pkg
// Shared types and constants of the weighted rgb histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrh_pkg;

	localparam int CFG_W     = 3;
	localparam int BPC_RESET = 4;
	localparam int FUNC_W    = 1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ACCUM = 1'b0,
		FUNC_READ  = 1'b1
	} func_t;

endpackage

// ----- hw/rtl/wrh_if.sv -----
// ----------------------------------------------------------------------------
// wrh_if
// Valid/ready channels of the weighted rgb histogram: pixel items in and
// bin totals out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wrh_pixel_if #(
	parameter int CHAN_BITS   = 4,
	parameter int WEIGHT_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic [wrh_pkg::FUNC_W-1:0]  func;
	logic [CHAN_BITS-1:0]        red_bin;
	logic [CHAN_BITS-1:0]        green_bin;
	logic [CHAN_BITS-1:0]        blue_bin;
	logic [WEIGHT_BITS-1:0]      weight;

	modport source (output valid, func, red_bin, green_bin, blue_bin, weight, input ready);
	modport sink   (input valid, func, red_bin, green_bin, blue_bin, weight, output ready);
endinterface

interface wrh_result_if #(
	parameter int BIN_BITS = 40
);
	logic                valid;
	logic                ready;
	logic [BIN_BITS-1:0] bin_total;

	modport source (output valid, bin_total, input ready);
	modport sink   (input valid, bin_total, output ready);
endinterface

// ----- hw/rtl/weighted_rgb_histogram_core.sv -----
// ----------------------------------------------------------------------------
// weighted_rgb_histogram_core
// Weighted 3-d color histogram. Accumulate items add a weight to the bin
// red + green<<b + blue<<2b with saturation; read items return a bin and
// clear it. After reset a clearing pass writes zero to every bin, one bin a
// cycle, over all 2**(3*MAX_CHANNEL_BITS) bins (4096 by default) while pixel
// ready stays low; configuration writes are taken throughout. After that the
// block takes one item per cycle: the bins live in one memory with one read
// and one write port, an item reads its bin in the cycle it is accepted and
// writes it back in the next, and the last write is forwarded to an item on
// the same bin that follows at once. A read result goes from the write-back
// stage into a two-entry output queue, which absorbs stalls on the result
// side, and input ready drops only when that queue would overfill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_rgb_histogram_core #(
	parameter int MAX_CHANNEL_BITS = 4,
	parameter int WEIGHT_BITS      = 16,
	parameter int BIN_BITS         = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wrh_pkg::CFG_W-1:0]     cfg_wdata,
	wrh_pixel_if.sink                     pixel,
	wrh_result_if.source                  result
);

	localparam int ADDR_W = 3 * MAX_CHANNEL_BITS;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int SUM_W  = ((BIN_BITS > WEIGHT_BITS) ? BIN_BITS : WEIGHT_BITS) + 1;
	localparam logic [wrh_pkg::CFG_W-1:0] MAX_BPC = wrh_pkg::CFG_W'(MAX_CHANNEL_BITS);

	logic [wrh_pkg::CFG_W-1:0] bpc_q;
	logic [wrh_pkg::CFG_W-1:0] nb;
	logic [MAX_CHANNEL_BITS-1:0] chan_mask;
	logic [ADDR_W-1:0] idx;

	logic clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic v_s1;
	logic [wrh_pkg::FUNC_W-1:0] func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [WEIGHT_BITS-1:0] weight_s1;
	logic [BIN_BITS-1:0] rdata_s1;

	logic fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [BIN_BITS-1:0] fwd_data_q;

	logic [BIN_BITS-1:0] mem [DEPTH];

	logic [BIN_BITS-1:0] old_val;
	logic [SUM_W-1:0] sum;
	logic [BIN_BITS-1:0] new_val;
	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [BIN_BITS-1:0] wdata;
	logic is_read_s1;

	logic out_valid_q;
	logic [BIN_BITS-1:0] out_q;
	logic spare_valid_q;
	logic [BIN_BITS-1:0] spare_q;
	logic pop;
	logic push;
	logic [2:0] load;
	logic accept;

	// effective bits per channel
	always_comb begin
		if (bpc_q == '0) begin
			nb = wrh_pkg::CFG_W'(1);
		end else if (bpc_q > MAX_BPC) begin
			nb = MAX_BPC;
		end else begin
			nb = bpc_q;
		end
	end

	assign chan_mask = ~({MAX_CHANNEL_BITS{1'b1}} << nb);

	assign idx = ADDR_W'(pixel.red_bin & chan_mask)
		| (ADDR_W'(pixel.green_bin & chan_mask) << nb)
		| (ADDR_W'(pixel.blue_bin & chan_mask) << {nb, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q <= wrh_pkg::CFG_W'(wrh_pkg::BPC_RESET);
		end else if (cfg_we) begin
			bpc_q <= cfg_wdata;
		end
	end

	// output queue accounting
	assign pop        = out_valid_q && result.ready;
	assign is_read_s1 = v_s1 && (func_s1 == wrh_pkg::FUNC_READ);
	assign push       = is_read_s1;
	assign load       = 3'(out_valid_q) + 3'(spare_valid_q) + 3'(is_read_s1) - 3'(pop);
	assign pixel.ready = !clr_busy_q && (load <= 3'd1);
	assign accept     = pixel.valid && pixel.ready;

	// read-modify-write
	assign old_val = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata_s1;
	assign sum     = SUM_W'(old_val) + SUM_W'(weight_s1);
	assign new_val = (|sum[SUM_W-1:BIN_BITS]) ? {BIN_BITS{1'b1}} : sum[BIN_BITS-1:0];

	assign we    = clr_busy_q || v_s1;
	assign waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign wdata = (clr_busy_q || is_read_s1) ? '0 : new_val;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[idx];
	end

	always_ff @(posedge clk) begin
		addr_s1    <= idx;
		func_s1    <= pixel.func;
		weight_s1  <= pixel.weight;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			v_s1        <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			v_s1        <= accept;
			fwd_valid_q <= v_s1;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == {ADDR_W{1'b1}}) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			if (spare_valid_q) begin
				out_valid_q   <= 1'b1;
				spare_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (spare_valid_q) begin
				out_q   <= spare_q;
				spare_q <= old_val;
			end else begin
				out_q <= old_val;
			end
		end else if (push) begin
			spare_q <= old_val;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.bin_total = out_q;

	// result queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && out_valid_q && spare_valid_q && !pop))
		else $error("result queue overflow");

	// clearing pass never shares the write port with an item
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s1)
		else $error("item in flight during clearing pass");

	// accumulate never lowers a bin
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (func_s1 == wrh_pkg::FUNC_ACCUM)) |-> (new_val >= old_val))
		else $error("accumulate lowered a bin");

	// a read right after a read of the same bin sees the cleared bin
	a_fwd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(is_read_s1 && fwd_valid_q && (fwd_addr_q == addr_s1)
			&& $past(func_s1 == wrh_pkg::FUNC_READ)) |-> (old_val == '0))
		else $error("forwarded clear lost");

endmodule

// ----- sim/tb_weighted_rgb_histogram_core.sv -----
// ----------------------------------------------------------------------------
// tb_weighted_rgb_histogram_core
// Self-checking bench for the weighted rgb histogram core. A behavioral
// copy of the bin store follows every accepted pixel item, and each read
// total is compared against the oldest predicted total. Directed items cover
// field extremes, the clamping of bits per channel, masking of wide channels,
// layout changes without clearing, and read-then-accumulate on one bin. Random
// phases then sweep several bits-per-channel settings with hot-bin traffic,
// sender bursts and result-side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_weighted_rgb_histogram_core;

	localparam int CHAN_W         = 4;
	localparam int WEIGHT_W       = 16;
	localparam int TOTAL_W        = 40;
	localparam int MAX_BITS       = 4;
	localparam int INDEX_W        = 3 * CHAN_W;
	localparam int STORE_DEPTH    = 1 << (3 * MAX_BITS);
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_ITEMS    = 225;
	localparam int HOT_COUNT      = 8;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_BURSTY
	} stall_mode_t;

	typedef struct packed {
		wrh_pkg::func_t      func;
		logic [CHAN_W-1:0]   red_bin;
		logic [CHAN_W-1:0]   green_bin;
		logic [CHAN_W-1:0]   blue_bin;
		logic [WEIGHT_W-1:0] weight;
	} pixel_item_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [wrh_pkg::CFG_W-1:0] cfg_wdata;

	wrh_pixel_if #(.CHAN_BITS(CHAN_W), .WEIGHT_BITS(WEIGHT_W)) pix_if ();
	wrh_result_if #(.BIN_BITS(TOTAL_W)) res_if ();

	weighted_rgb_histogram_core #(
		.MAX_CHANNEL_BITS(MAX_BITS),
		.WEIGHT_BITS(WEIGHT_W),
		.BIN_BITS(TOTAL_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pixel(pix_if),
		.result(res_if)
	);

	always #6 clk = ~clk;

	logic [TOTAL_W-1:0]        bin_model [STORE_DEPTH];
	logic [wrh_pkg::CFG_W-1:0] bpc_model;
	logic [TOTAL_W-1:0]        expected_totals [$];
	logic [INDEX_W-1:0]        hot_bins [HOT_COUNT];

	int          mismatch_count = 0;
	int          items_sent = 0;
	int          reads_sent = 0;
	int          totals_checked = 0;
	int          settings_used = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;

	function automatic int unsigned bin_index(input pixel_item_t it);
		int unsigned nb;
		int unsigned m;
		nb = (bpc_model == 0) ? 1 : ((bpc_model > MAX_BITS) ? MAX_BITS : bpc_model);
		m = (1 << nb) - 1;
		return ((it.red_bin & m) | ((it.green_bin & m) << nb) |
			((it.blue_bin & m) << (2 * nb))) & (STORE_DEPTH - 1);
	endfunction

	function automatic void update_bins(input pixel_item_t it);
		int unsigned      idx;
		logic [TOTAL_W:0] sum;
		idx = bin_index(it);
		if (it.func == wrh_pkg::FUNC_READ) begin
			expected_totals.push_back(bin_model[idx]);
			bin_model[idx] = '0;
			reads_sent++;
		end else begin
			sum = bin_model[idx] + it.weight;
			bin_model[idx] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
		end
	endfunction

	function automatic pixel_item_t make_item(input wrh_pkg::func_t f, input int r,
			input int g, input int b, input int w);
		pixel_item_t it;
		it.func = f;
		it.red_bin = CHAN_W'(r);
		it.green_bin = CHAN_W'(g);
		it.blue_bin = CHAN_W'(b);
		it.weight = WEIGHT_W'(w);
		return it;
	endfunction

	function automatic pixel_item_t random_item();
		pixel_item_t        it;
		logic [INDEX_W-1:0] hb;
		int                 sel;
		it.func = ($urandom_range(0, 99) < 30) ? wrh_pkg::FUNC_READ : wrh_pkg::FUNC_ACCUM;
		if ($urandom_range(0, 9) < 7) begin
			hb = hot_bins[$urandom_range(0, HOT_COUNT - 1)];
			it.red_bin = hb[CHAN_W-1:0];
			it.green_bin = hb[2*CHAN_W-1:CHAN_W];
			it.blue_bin = hb[3*CHAN_W-1:2*CHAN_W];
		end else begin
			it.red_bin = CHAN_W'($urandom_range(0, 15));
			it.green_bin = CHAN_W'($urandom_range(0, 15));
			it.blue_bin = CHAN_W'($urandom_range(0, 15));
		end
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			it.weight = '0;
		end else if (sel == 1) begin
			it.weight = '1;
		end else begin
			it.weight = WEIGHT_W'($urandom_range(0, 65535));
		end
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_item(input pixel_item_t it);
		int gap;
		if (gaps_on && burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			pix_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end else begin
			@(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.func <= it.func;
		pix_if.red_bin <= it.red_bin;
		pix_if.green_bin <= it.green_bin;
		pix_if.blue_bin <= it.blue_bin;
		pix_if.weight <= it.weight;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		update_bins(it);
		items_sent++;
		burst_left--;
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		while (expected_totals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bpc(input int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= wrh_pkg::CFG_W'(v);
		@(posedge clk);
		bpc_model = wrh_pkg::CFG_W'(v);
		settings_used++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side stall pattern
	always @(negedge clk) begin
		case (stall_mode)
			STALL_NONE: begin
				res_if.ready <= 1'b1;
			end
			STALL_RANDOM: begin
				res_if.ready <= ($urandom_range(0, 2) != 0);
			end
			default: begin
				if (stall_left > 0) begin
					res_if.ready <= 1'b0;
					stall_left--;
				end else begin
					res_if.ready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						stall_left = $urandom_range(1, 30);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		logic [TOTAL_W-1:0] want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (expected_totals.size() == 0) begin
				report_mismatch($sformatf("bin total %h with no read pending",
					res_if.bin_total));
			end else begin
				want = expected_totals.pop_front();
				if (res_if.bin_total !== want)
					report_mismatch($sformatf("bin_total got %h want %h",
						res_if.bin_total, want));
				totals_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_if.valid === 1'b1 && pix_if.ready === 1'b1) ||
				(res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_clear_after_reset();
		stall_mode = STALL_BURSTY;
		gaps_on = 1'b1;
		write_bpc(wrh_pkg::BPC_RESET);
		send_item(make_item(wrh_pkg::FUNC_READ, 0, 0, 0, 0));
		send_item(make_item(wrh_pkg::FUNC_READ, 15, 15, 15, 16'hffff));
	endtask

	task automatic test_field_extremes();
		stall_mode = STALL_RANDOM;
		gaps_on = 1'b1;
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 0, 0, 0, 16'hffff));
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 15, 15, 15, 0));
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 15, 15, 15, 16'hffff));
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 15, 15, 15, 1));
		send_item(make_item(wrh_pkg::FUNC_READ, 15, 15, 15, 0));
		send_item(make_item(wrh_pkg::FUNC_READ, 0, 0, 0, 16'hffff));
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 5, 10, 3, 16'h1234));
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 5, 10, 3, 16'habcd));
		send_item(make_item(wrh_pkg::FUNC_READ, 5, 10, 3, 0));
	endtask

	task automatic test_read_then_accumulate();
		drain_and_settle();
		stall_mode = STALL_NONE;
		gaps_on = 1'b0;
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 7, 2, 9, 16'h0100));
		send_item(make_item(wrh_pkg::FUNC_READ, 7, 2, 9, 0));
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 7, 2, 9, 16'h0007));
		send_item(make_item(wrh_pkg::FUNC_READ, 7, 2, 9, 0));
	endtask

	task automatic test_bpc_clamp();
		drain_and_settle();
		stall_mode = STALL_BURSTY;
		gaps_on = 1'b1;
		// zero acts as one bit, wide channels are masked
		write_bpc(0);
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 15, 14, 13, 100));
		send_item(make_item(wrh_pkg::FUNC_READ, 1, 0, 1, 0));
		drain_and_settle();
		// values above the maximum act as the maximum
		write_bpc(7);
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 9, 9, 9, 50));
		send_item(make_item(wrh_pkg::FUNC_READ, 9, 9, 9, 0));
	endtask

	task automatic test_layout_change();
		drain_and_settle();
		write_bpc(4);
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 1, 0, 0, 300));
		drain_and_settle();
		write_bpc(2);
		send_item(make_item(wrh_pkg::FUNC_READ, 1, 0, 0, 0));
		send_item(make_item(wrh_pkg::FUNC_ACCUM, 0, 1, 0, 20));
		drain_and_settle();
		write_bpc(4);
		send_item(make_item(wrh_pkg::FUNC_READ, 4, 0, 0, 0));
	endtask

	task automatic test_random_phases();
		int phase_bpc [8];
		phase_bpc = '{4, 1, 3, 0, 2, 7, 5, 6};
		for (int p = 0; p < 8; p++) begin
			drain_and_settle();
			write_bpc(phase_bpc[p]);
			foreach (hot_bins[i])
				hot_bins[i] = INDEX_W'($urandom);
			stall_mode = stall_mode_t'(p % 3);
			gaps_on = (p % 4) != 1;
			burst_left = 0;
			repeat (PHASE_ITEMS) send_item(random_item());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pix_if.valid = 1'b0;
		pix_if.func = wrh_pkg::FUNC_ACCUM;
		pix_if.red_bin = '0;
		pix_if.green_bin = '0;
		pix_if.blue_bin = '0;
		pix_if.weight = '0;
		res_if.ready = 1'b0;
		bpc_model = wrh_pkg::CFG_W'(wrh_pkg::BPC_RESET);
		foreach (bin_model[i])
			bin_model[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_clear_after_reset();
		test_field_extremes();
		test_read_then_accumulate();
		test_bpc_clamp();
		test_layout_change();
		test_random_phases();
		drain_and_settle();

		if (expected_totals.size() != 0)
			report_mismatch($sformatf("%0d bin totals never arrived", expected_totals.size()));
		$display("covered %0d pixel items, %0d bin reads, %0d totals checked",
			items_sent, reads_sent, totals_checked);
		$display("bits per channel written %0d times, 0 through 7 included", settings_used);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
